// File: rtl/vccc_pkg.sv
// ----------------------------------------------------------------------------
// Coulomb counter package
// Constants shared by the virtual current coulomb counter: register indexes,
// the throttle zero point and the divisors used by the iterative divider.
// ----------------------------------------------------------------------------
package vccc_pkg;

  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_CURRENT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_THROTTLE_SCALE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_USE_MEASURED = 2'd2;

  localparam logic [11:0] THROTTLE_ZERO = 12'd1000;

  // The divider retires this many quotient bits per cycle.
  localparam int unsigned DIV_RADIX_BITS = 4;
  localparam int unsigned DIV_WORD_W     = 72;
  localparam int unsigned DIV_DIVISOR_W  = 22;
  localparam int unsigned DIV_REM_W      = DIV_DIVISOR_W + 1;
  localparam int unsigned DIV_COUNT_W    = 5;

  localparam logic [DIV_DIVISOR_W-1:0] DIVISOR_SQUARE = 22'd50;
  localparam logic [DIV_DIVISOR_W-1:0] DIVISOR_SCALE  = 22'd100;
  // One hour is 3600000000 us, which is 2^10 * 3515625. With the Q16 scale
  // the energy is the accumulator times 64 divided by 3515625.
  localparam logic [DIV_DIVISOR_W-1:0] DIVISOR_ENERGY = 22'd3515625;

  localparam logic [DIV_COUNT_W-1:0] STEPS_SQUARE = 5'd6;
  localparam logic [DIV_COUNT_W-1:0] STEPS_SCALE  = 5'd8;
  localparam logic [DIV_COUNT_W-1:0] STEPS_ENERGY = 5'd18;

endpackage

// File: rtl/virtual_current_coulomb_counter_top.sv
// ----------------------------------------------------------------------------
// Virtual current coulomb counter
// Estimates or takes the current of each sample and integrates it over time
// into a saturating charge accumulator, reporting charge in mAh, Q16.
// ----------------------------------------------------------------------------
// Usage:
// A sample request (throttle, measured_milliamps, timestamp_us) is taken when
// sample_valid is high and sample_stall is low. The block then runs one
// shared multiplier and one shared divider, which retires four quotient bits
// per cycle, under a sequencer, and holds sample_stall high until the result
// request has been taken.
// In virtual mode the sequencer runs these steps after the sample is taken
// (square, divide by 50, scale, divide by 100, charge product, accumulate,
// divide for the energy); in measured mode it runs only the last three. The
// divider steps of the energy conversion dominate. A new sample can be taken
// in the cycle after the result is accepted.
// The result request is held on result_valid with a stable payload for as
// long as result_stall is high. Configuration writes on the cfg channel are
// always ready and are meant to be issued while no sample is in flight.
// Reset clears the configuration, the stored time and the accumulator.
// ----------------------------------------------------------------------------
module virtual_current_coulomb_counter_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [vccc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [vccc_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  logic [10:0]                          throttle,
  input  logic signed [15:0]                   measured_milliamps,
  input  logic [31:0]                          timestamp_us,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output logic signed [23:0]                   current_milliamps,
  output logic signed [48:0]                   energy_mah_q16
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQUARE,
    S_LOAD_SQUARE,
    S_FACTOR,
    S_SCALE,
    S_LOAD_SCALE,
    S_CURRENT,
    S_CHARGE,
    S_ACCUM,
    S_LOAD_ENERGY,
    S_DIVIDE,
    S_RESULT
  } state_t;

  typedef enum logic [1:0] {
    DIV_SQUARE,
    DIV_SCALE,
    DIV_ENERGY
  } div_kind_t;

  state_t state;

  logic signed [15:0] idle_current;
  logic signed [15:0] scale;
  logic               use_measured;

  logic [10:0]        throttle_reg;
  logic [31:0]        timestamp_reg;
  logic [31:0]        previous_time;
  logic signed [63:0] acc;
  logic signed [16:0] factor;
  logic signed [58:0] prod;

  logic [vccc_pkg::DIV_REM_W-1:0]     div_rem;
  logic [vccc_pkg::DIV_WORD_W-1:0]    div_word;
  logic [vccc_pkg::DIV_DIVISOR_W-1:0] div_divisor;
  logic [vccc_pkg::DIV_COUNT_W-1:0]   div_count;
  div_kind_t                          div_kind;
  logic                               div_neg;

  logic [vccc_pkg::DIV_REM_W-1:0]  step_rem;
  logic [vccc_pkg::DIV_WORD_W-1:0] step_word;

  logic signed [11:0] t_val;
  logic signed [24:0] mul_a;
  logic signed [33:0] mul_b;
  logic signed [58:0] mul_p;
  logic [31:0]        dt;
  logic signed [64:0] acc_sum;
  logic               acc_ovf;
  logic signed [63:0] acc_next;
  logic signed [58:0] prod_mag;
  logic signed [63:0] acc_mag;
  logic signed [24:0] idle_ma;
  logic signed [24:0] quot_scale;
  logic signed [24:0] current_sum;
  logic [vccc_pkg::DIV_WORD_W-1:0] energy_signed;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != S_IDLE);

  assign t_val = $signed({1'b0, throttle_reg} - vccc_pkg::THROTTLE_ZERO);
  assign dt    = timestamp_reg - previous_time;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQUARE: begin
        mul_a = {{13{t_val[11]}}, t_val};
        mul_b = {{22{t_val[11]}}, t_val};
      end
      S_SCALE: begin
        mul_a = {{8{factor[16]}}, factor};
        mul_b = {{18{scale[15]}}, scale};
      end
      S_CHARGE: begin
        mul_a = {current_milliamps[23], current_milliamps};
        mul_b = {2'b00, dt};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    step_rem  = div_rem;
    step_word = div_word;
    for (int i = 0; i < vccc_pkg::DIV_RADIX_BITS; i++) begin
      step_rem  = {step_rem[vccc_pkg::DIV_REM_W-2:0], step_word[vccc_pkg::DIV_WORD_W-1]};
      step_word = {step_word[vccc_pkg::DIV_WORD_W-2:0], 1'b0};
      if (step_rem >= {1'b0, div_divisor}) begin
        step_rem     = step_rem - {1'b0, div_divisor};
        step_word[0] = 1'b1;
      end
    end
  end

  assign acc_sum  = {acc[63], acc} + {{6{prod[58]}}, prod};
  assign acc_ovf  = acc_sum[64] ^ acc_sum[63];
  assign acc_next = acc_ovf ? (acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                            : acc_sum[63:0];

  assign prod_mag = prod[58] ? -prod : prod;
  assign acc_mag  = acc[63] ? -acc : acc;

  assign idle_ma     = {{6{idle_current[15]}}, idle_current, 3'b000}
                     + {{8{idle_current[15]}}, idle_current, 1'b0};
  assign quot_scale  = div_neg ? -$signed({1'b0, div_word[23:0]})
                               : $signed({1'b0, div_word[23:0]});
  assign current_sum = idle_ma + quot_scale;

  assign energy_signed = div_neg ? -step_word : step_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      idle_current  <= '0;
      scale         <= '0;
      use_measured  <= 1'b0;
      previous_time <= '0;
      acc           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vccc_pkg::REG_IDLE_CURRENT:   idle_current <= $signed(cfg_data);
          vccc_pkg::REG_THROTTLE_SCALE: scale <= $signed(cfg_data);
          vccc_pkg::REG_USE_MEASURED:   use_measured <= cfg_data[0];
          default: begin
          end
        endcase
      end
      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            throttle_reg  <= throttle;
            timestamp_reg <= timestamp_us;
            if (use_measured) begin
              current_milliamps <= {{8{measured_milliamps[15]}}, measured_milliamps};
              state             <= S_CHARGE;
            end else begin
              state <= S_SQUARE;
            end
          end
        end
        S_SQUARE: begin
          prod  <= mul_p;
          state <= S_LOAD_SQUARE;
        end
        S_LOAD_SQUARE: begin
          div_rem     <= '0;
          div_word    <= {prod[23:0], 48'd0};
          div_divisor <= vccc_pkg::DIVISOR_SQUARE;
          div_count   <= vccc_pkg::STEPS_SQUARE;
          div_kind    <= DIV_SQUARE;
          div_neg     <= 1'b0;
          state       <= S_DIVIDE;
        end
        S_FACTOR: begin
          factor <= {{5{t_val[11]}}, t_val} + $signed({2'b00, div_word[14:0]});
          state  <= S_SCALE;
        end
        S_SCALE: begin
          prod  <= mul_p;
          state <= S_LOAD_SCALE;
        end
        S_LOAD_SCALE: begin
          div_rem     <= '0;
          div_word    <= {prod_mag[31:0], 40'd0};
          div_divisor <= vccc_pkg::DIVISOR_SCALE;
          div_count   <= vccc_pkg::STEPS_SCALE;
          div_kind    <= DIV_SCALE;
          div_neg     <= prod[58];
          state       <= S_DIVIDE;
        end
        S_CURRENT: begin
          current_milliamps <= current_sum[23:0];
          state             <= S_CHARGE;
        end
        S_CHARGE: begin
          if (previous_time != 32'd0) begin
            prod <= mul_p;
          end else begin
            prod <= '0;
          end
          previous_time <= timestamp_reg;
          state         <= S_ACCUM;
        end
        S_ACCUM: begin
          acc   <= acc_next;
          state <= S_LOAD_ENERGY;
        end
        S_LOAD_ENERGY: begin
          div_rem     <= '0;
          div_word    <= {2'b00, acc_mag, 6'd0};
          div_divisor <= vccc_pkg::DIVISOR_ENERGY;
          div_count   <= vccc_pkg::STEPS_ENERGY;
          div_kind    <= DIV_ENERGY;
          div_neg     <= acc[63];
          state       <= S_DIVIDE;
        end
        S_DIVIDE: begin
          div_rem   <= step_rem;
          div_word  <= step_word;
          div_count <= div_count - 1'b1;
          if (div_count == 5'd1) begin
            case (div_kind)
              DIV_SQUARE: state <= S_FACTOR;
              DIV_SCALE:  state <= S_CURRENT;
              DIV_ENERGY: begin
                energy_mah_q16 <= energy_signed[48:0];
                result_valid   <= 1'b1;
                state          <= S_RESULT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RESULT: begin
          if (!result_stall) begin
            result_valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A pending result keeps the sample side closed.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_stall)
    else $error("result pending while samples are accepted");

  // Once a sample is taken the block is busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> (sample_stall && !result_valid))
    else $error("block not busy after a sample");

  // A nonnegative charge step never lowers the accumulator.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ACCUM && !prod[58]) |=> (acc >= $past(acc)))
    else $error("accumulator decreased on a nonnegative step");

  // A delivered result is not presented again.
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_stall) |=> !result_valid)
    else $error("result repeated after delivery");

endmodule

// File: sim/tb_virtual_current_coulomb_counter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the virtual current coulomb counter
// Drives sample requests and configuration writes and predicts the current
// and the saturating charge of every sample. Each result request is checked
// against the prediction. The run covers a directed opening, random phases
// under random settings, and long heavy-current runs that drive the charge
// into both saturation limits.
// ----------------------------------------------------------------------------
module tb_virtual_current_coulomb_counter_top;

  localparam logic [vccc_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam longint SQUARE_DIVISOR = 50;
  localparam longint SCALE_DIVISOR = 100;
  localparam longint MA_PER_CA = 10;
  localparam longint US_PER_HOUR = 64'd3_600_000_000;
  localparam longint Q16_ONE = 65536;
  localparam longint CHARGE_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam longint CHARGE_MIN = 64'sh8000_0000_0000_0000;
  localparam int HOLDOFF_CYCLES = 400;

  typedef struct packed {
    logic [10:0] throttle;
    logic signed [15:0] milliamps;
    logic [31:0] stamp;
  } sample_t;

  typedef struct packed {
    logic signed [23:0] milliamps;
    logic signed [48:0] charge_q16;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vccc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [vccc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic [10:0] throttle = '0;
  logic signed [15:0] measured_milliamps = '0;
  logic [31:0] timestamp_us = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [23:0] current_milliamps;
  logic signed [48:0] energy_mah_q16;

  sample_t pending_samples[$];
  reading_t expected_readings[$];
  bit sample_fire = 1'b0;
  bit steady = 1'b0;
  int mismatch_count = 0;
  int holdoffs_asked = 0;
  int holdoffs_granted = 0;
  int holdoff_left = 0;
  logic [31:0] stamp_cursor = 32'd5000;

  logic signed [15:0] idle_centiamps = '0;
  logic signed [15:0] throttle_scale = '0;
  logic measured_mode = 1'b0;
  logic [31:0] last_stamp = '0;
  longint charge_mau = 0;

  virtual_current_coulomb_counter_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .throttle(throttle),
    .measured_milliamps(measured_milliamps),
    .timestamp_us(timestamp_us),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .current_milliamps(current_milliamps),
    .energy_mah_q16(energy_mah_q16)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_virtual_current_coulomb_counter_top: errors");
    $finish;
  end

  function automatic reading_t predict_reading(input sample_t s);
    reading_t rd;
    longint amps, offset, factor, step, energy;
    logic [31:0] elapsed;
    if (measured_mode) begin
      amps = longint'(s.milliamps);
    end else begin
      offset = longint'(s.throttle) - longint'(vccc_pkg::THROTTLE_ZERO);
      factor = offset + offset * offset / SQUARE_DIVISOR;
      amps = longint'(idle_centiamps) * MA_PER_CA
           + factor * longint'(throttle_scale) / SCALE_DIVISOR;
    end
    if (last_stamp != 0) begin
      elapsed = s.stamp - last_stamp;
      step = amps * longint'({32'd0, elapsed});
      if (step > 0 && charge_mau > CHARGE_MAX - step) begin
        charge_mau = CHARGE_MAX;
      end else if (step < 0 && charge_mau < CHARGE_MIN - step) begin
        charge_mau = CHARGE_MIN;
      end else begin
        charge_mau = charge_mau + step;
      end
    end
    last_stamp = s.stamp;
    energy = (charge_mau / US_PER_HOUR) * Q16_ONE
           + (charge_mau % US_PER_HOUR) * Q16_ONE / US_PER_HOUR;
    rd.milliamps = amps[23:0];
    rd.charge_q16 = energy[48:0];
    return rd;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    reading_t want;
    sample_t seen;
    if (rst) begin
      sample_fire = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          vccc_pkg::REG_IDLE_CURRENT: idle_centiamps = cfg_data;
          vccc_pkg::REG_THROTTLE_SCALE: throttle_scale = cfg_data;
          vccc_pkg::REG_USE_MEASURED: measured_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("unexpected result, current", current_milliamps, 0);
        end else begin
          want = expected_readings.pop_front();
          if (current_milliamps !== want.milliamps) begin
            report_mismatch("current_milliamps", current_milliamps, want.milliamps);
          end
          if (energy_mah_q16 !== want.charge_q16) begin
            report_mismatch("energy_mah_q16", energy_mah_q16, want.charge_q16);
          end
        end
      end
      sample_fire = sample_valid && !sample_stall;
      if (sample_fire) begin
        seen.throttle = throttle;
        seen.milliamps = measured_milliamps;
        seen.stamp = timestamp_us;
        expected_readings.push_back(predict_reading(seen));
      end
    end
  end

  always @(negedge clk) begin
    sample_t next_sample;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || sample_fire) begin
      if (pending_samples.size() != 0 && (steady || $urandom_range(99, 0) >= 9)) begin
        next_sample = pending_samples.pop_front();
        sample_valid <= 1'b1;
        throttle <= next_sample.throttle;
        measured_milliamps <= next_sample.milliamps;
        timestamp_us <= next_sample.stamp;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (holdoff_left != 0) begin
      result_stall <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_granted != holdoffs_asked) begin
      result_stall <= 1'b1;
      holdoffs_granted <= holdoffs_granted + 1;
      holdoff_left <= HOLDOFF_CYCLES;
    end else begin
      result_stall <= !steady && ($urandom_range(99, 0) < 9);
    end
  end

  task automatic write_reg(input logic [vccc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    while (pending_samples.size() != 0 || sample_valid || expected_readings.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic start_phase(input bit no_gaps);
    @(posedge clk);
    steady = no_gaps;
  endtask

  function automatic logic [15:0] reg_value();
    case ($urandom_range(3, 0))
      0: return 16'h8000;
      1: return 16'h7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_config();
    write_reg(vccc_pkg::REG_IDLE_CURRENT, reg_value());
    write_reg(vccc_pkg::REG_THROTTLE_SCALE, reg_value());
    write_reg(vccc_pkg::REG_USE_MEASURED, 16'($urandom));
    if ($urandom_range(1, 0) == 1) begin
      write_reg(REG_UNUSED, 16'($urandom));
    end
  endtask

  // A regular sample has a nominal throttle and a timestamp a little later
  // than the last one. Noise samples use any throttle and a zero, earlier or
  // arbitrary timestamp.
  function automatic sample_t make_sample(input bit regular);
    sample_t s;
    int unsigned pick;
    pick = $urandom_range(99, 0);
    s.milliamps = 16'($urandom);
    if (regular) begin
      s.throttle = 11'($urandom_range(2000, 1000));
      stamp_cursor = stamp_cursor + $urandom_range(50000, 1);
    end else begin
      s.throttle = 11'($urandom_range(2047, 0));
      if (pick < 25) begin
        stamp_cursor = '0;
      end else if (pick < 50) begin
        stamp_cursor = stamp_cursor - $urandom_range(100000, 1);
      end else begin
        stamp_cursor = $urandom;
      end
    end
    s.stamp = stamp_cursor;
    return s;
  endfunction

  // Stepping the timestamp slightly backwards makes every interval close
  // to the full 32-bit range, so the charge moves as fast as it can.
  function automatic sample_t heavy_sample();
    sample_t s;
    s.throttle = 11'($urandom_range(2047, 2030));
    s.milliamps = 16'($urandom);
    stamp_cursor = stamp_cursor - $urandom_range(64, 1);
    s.stamp = stamp_cursor;
    return s;
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    start_phase(1'b0);
    pending_samples.push_back('{11'd1500, 16'sd0, 32'd1000});
    wait_quiet();

    write_reg(vccc_pkg::REG_IDLE_CURRENT, 16'd123);
    write_reg(vccc_pkg::REG_THROTTLE_SCALE, 16'd4567);
    write_reg(vccc_pkg::REG_USE_MEASURED, 16'h0000);
    write_reg(REG_UNUSED, 16'hffff);
    start_phase(1'b0);
    pending_samples.push_back('{11'd0, 16'sh8000, 32'd5000});
    pending_samples.push_back('{11'd2047, 16'sh7fff, 32'd6000});
    pending_samples.push_back('{11'd1000, 16'sd0, 32'd0});
    pending_samples.push_back('{11'd999, -16'sd1, 32'd777});
    pending_samples.push_back('{11'd1001, 16'sd1234, 32'd100});
    pending_samples.push_back('{11'd2000, -16'sd1234, 32'd200});
    pending_samples.push_back('{11'd1, 16'sd0, 32'hffff_ffff});
    wait_quiet();

    write_reg(vccc_pkg::REG_USE_MEASURED, 16'h0001);
    start_phase(1'b0);
    pending_samples.push_back('{11'd1500, 16'sh7fff, 32'h0000_0001});
    pending_samples.push_back('{11'd1500, 16'sh8000, 32'h8000_0000});
    pending_samples.push_back('{11'd0, -16'sd1, 32'h8000_0005});
    pending_samples.push_back('{11'd2047, 16'sd0, 32'hffff_fff0});
    wait_quiet();

    write_reg(vccc_pkg::REG_IDLE_CURRENT, 16'h8000);
    write_reg(vccc_pkg::REG_THROTTLE_SCALE, 16'h8000);
    write_reg(vccc_pkg::REG_USE_MEASURED, 16'hfffe);
    start_phase(1'b0);
    pending_samples.push_back('{11'd0, 16'sd5, 32'h0001_0000});
    pending_samples.push_back('{11'd2047, 16'sd5, 32'h0002_0000});
    pending_samples.push_back('{11'd1000, 16'sd5, 32'h0003_0000});
    wait_quiet();

    write_reg(vccc_pkg::REG_IDLE_CURRENT, 16'h7fff);
    write_reg(vccc_pkg::REG_THROTTLE_SCALE, 16'h7fff);
    start_phase(1'b0);
    pending_samples.push_back('{11'd2047, 16'sd0, 32'h0004_0000});
    pending_samples.push_back('{11'd0, 16'sd0, 32'h0005_0000});
    wait_quiet();

    for (int phase = 0; phase < 10; phase++) begin
      random_config();
      start_phase(phase == 3);
      repeat ($urandom_range(100, 72)) begin
        pending_samples.push_back(make_sample($urandom_range(99, 0) >= 15));
      end
      if (phase == 6) begin
        holdoffs_asked++;
      end
      wait_quiet();
    end

    write_reg(vccc_pkg::REG_IDLE_CURRENT, 16'h7fff);
    write_reg(vccc_pkg::REG_THROTTLE_SCALE, 16'h7fff);
    write_reg(vccc_pkg::REG_USE_MEASURED, 16'h0000);
    start_phase(1'b0);
    repeat (330) pending_samples.push_back(heavy_sample());
    wait_quiet();

    write_reg(vccc_pkg::REG_IDLE_CURRENT, 16'h8000);
    write_reg(vccc_pkg::REG_THROTTLE_SCALE, 16'h8000);
    start_phase(1'b0);
    repeat (640) pending_samples.push_back(heavy_sample());
    wait_quiet();

    repeat (60) @(posedge clk);
    if (expected_readings.size() != 0) begin
      report_mismatch("results never delivered", expected_readings.size(), 0);
    end
    if (mismatch_count == 0) begin
      $display("tb_virtual_current_coulomb_counter_top: clean");
    end else begin
      $display("tb_virtual_current_coulomb_counter_top: errors");
    end
    $finish;
  end

endmodule
